>>> rtl/mtwg_pkg.sv
// mtwg_pkg: shared constants and word functions for the MT19937 generator.
// No dependencies; used by every module of the generator.
`timescale 1ns / 1ps

package mtwg_pkg;

  localparam int WORD_W       = 32;
  localparam int STATE_LENGTH = 624;
  localparam int TWIST_OFFSET = 397;

  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd6069;
  localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd4357;

  typedef logic [WORD_W-1:0] word_t;

  // One step of the twist recurrence.
  function automatic word_t twist_one(input word_t a, input word_t b, input word_t far);
    word_t y;
    y = (a & HIGH_BIT) | (b & LOW_BITS);
    return far ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
  endfunction

  // Output tempering.
  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> rtl/mtwg_cell.sv
// mtwg_cell: one word of the state ring; loads its neighbor's word on shift.
// Depends on mtwg_pkg.
`timescale 1ns / 1ps

module mtwg_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  mtwg_pkg::word_t d_in,
  output mtwg_pkg::word_t q_out
);

  mtwg_pkg::word_t word_r;
  mtwg_pkg::word_t word_nxt;

  assign word_nxt = shift_en ? d_in : word_r;

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q_out = word_r;

endmodule

>>> rtl/mtwg_chain.sv
// mtwg_chain: ring of mtwg_cell words; head is the current word, new words
// enter at the tail. Depends on mtwg_pkg and mtwg_cell.
`timescale 1ns / 1ps

module mtwg_chain #(
  parameter int STATE_LENGTH = mtwg_pkg::STATE_LENGTH,
  parameter int TWIST_OFFSET = mtwg_pkg::TWIST_OFFSET
) (
  input  logic            clk,
  input  logic            shift_en,
  input  mtwg_pkg::word_t shift_data,
  output mtwg_pkg::word_t tap_head,
  output mtwg_pkg::word_t tap_next,
  output mtwg_pkg::word_t tap_far
);

  mtwg_pkg::word_t q [STATE_LENGTH];

  for (genvar i = 0; i < STATE_LENGTH; i++) begin : g_cell
    mtwg_pkg::word_t d;
    if (i == STATE_LENGTH - 1) begin : g_tail
      assign d = shift_data;
    end else begin : g_mid
      assign d = q[i+1];
    end
    mtwg_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (d),
      .q_out    (q[i])
    );
  end

  assign tap_head = q[0];
  assign tap_next = q[1];
  assign tap_far  = q[TWIST_OFFSET];

endmodule

>>> rtl/mersenne_twister_word_generator_unit.sv
// mersenne_twister_word_generator_unit: MT19937 32-bit generator, top level.
// Depends on mtwg_pkg, mtwg_chain (and through it mtwg_cell).
`timescale 1ns / 1ps

// Channel  | Ports                               | Role
// ---------+-------------------------------------+-------------------------------
// input    | in_valid, in_ready, in_reseed       | draw request, reseed flag
// output   | out_valid, out_ready, out_random_word | tempered 32-bit word
// config   | cfg_wr_en, cfg_wr_data              | seed_value, reset 4357
//
// A plain draw twists the head word of the cell ring, tempers it into the
// output register and shifts the ring by one cell.
// A seeding request (reseed set, or the first request after reset) first
// fills the ring with STATE_LENGTH (624) seed words, one per cycle, shifted
// in at the tail through the 6069 multiplier, and then draws.
// Reset (rst_n low, synchronous) marks the ring unseeded; the ring itself
// holds no reset value. A result that waits on out_ready holds its slot;
// a new request is taken in the cycle the slot frees.

module mersenne_twister_word_generator_unit #(
  parameter int STATE_LENGTH = mtwg_pkg::STATE_LENGTH,
  parameter int TWIST_OFFSET = mtwg_pkg::TWIST_OFFSET
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_reseed,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mtwg_pkg::WORD_W-1:0] out_random_word,
  input  logic                        cfg_wr_en,
  input  logic [mtwg_pkg::WORD_W-1:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(STATE_LENGTH);

  typedef enum logic [1:0] {
    ST_IDLE,  // ready for a request
    ST_FILL,  // seeding the ring
    ST_DRAW   // ring seeded, draw pending
  } state_t;

  state_t          state_r,  state_nxt;
  logic            seeded_r, seeded_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  mtwg_pkg::word_t seed_r;
  mtwg_pkg::word_t fill_r,   fill_nxt;
  mtwg_pkg::word_t out_word_r, out_word_nxt;
  logic            out_valid_r, out_valid_nxt;

  mtwg_pkg::word_t tap_head, tap_next, tap_far;
  mtwg_pkg::word_t twisted;
  logic            slot_free;
  logic            accept;
  logic            need_seed;
  logic            do_draw;
  logic            do_fill;
  logic            shift_en;
  mtwg_pkg::word_t shift_data;

  // Seed register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= mtwg_pkg::SEED_DEFAULT;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign need_seed = in_reseed || !seeded_r;

  assign do_fill = (state_r == ST_FILL);
  assign do_draw = (accept && !need_seed) || ((state_r == ST_DRAW) && slot_free);

  // Incremental twist: head word uses its neighbor and the far tap; the far
  // tap already holds the new value once the ring has wrapped past it.
  assign twisted    = mtwg_pkg::twist_one(tap_head, tap_next, tap_far);
  assign shift_en   = do_fill || do_draw;
  assign shift_data = do_draw ? twisted : fill_r;

  mtwg_chain #(
    .STATE_LENGTH (STATE_LENGTH),
    .TWIST_OFFSET (TWIST_OFFSET)
  ) u_chain (
    .clk        (clk),
    .shift_en   (shift_en),
    .shift_data (shift_data),
    .tap_head   (tap_head),
    .tap_next   (tap_next),
    .tap_far    (tap_far)
  );

  always_comb begin
    state_nxt     = state_r;
    seeded_nxt    = seeded_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (accept && need_seed) begin
          state_nxt = ST_FILL;
          cnt_nxt   = '0;
          fill_nxt  = seed_r;
        end
      end
      ST_FILL: begin
        fill_nxt = fill_r * mtwg_pkg::SEED_MULT;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STATE_LENGTH - 1)) begin
          state_nxt  = ST_DRAW;
          seeded_nxt = 1'b1;
        end
      end
      ST_DRAW: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_draw) begin
      out_word_nxt  = mtwg_pkg::temper(twisted);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seeded_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seeded_r    <= seeded_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fill_r     <= fill_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule

>>> bench/testbench.sv
// testbench: self-checking bench for mersenne_twister_word_generator_unit.
// Depends on mtwg_pkg (widths, table size, constants) and the generator RTL.
`timescale 1ns / 1ps

module testbench;

  // Clock, reset and block ports. Every input starts at a known value.
  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_reseed = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  mtwg_pkg::word_t out_random_word;
  logic            cfg_wr_en = 1'b0;
  mtwg_pkg::word_t cfg_wr_data = '0;

  // Words the generator still owes us, oldest first.
  mtwg_pkg::word_t pending_words[$];
  int unsigned     mismatch_count = 0;

  // Shared pacing knobs: percent of idle cycles on each side, and a one-shot
  // request for a long receiver hold-off (cycles, zero when none asked).
  int unsigned idle_pct = 31;
  int unsigned stall_request = 0;

  // Shadow copy of the generator: table, read position, seed register.
  mtwg_pkg::word_t shadow_table[mtwg_pkg::STATE_LENGTH];
  int unsigned     shadow_pos;
  mtwg_pkg::word_t shadow_seed;

  mersenne_twister_word_generator_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_reseed       (in_reseed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop; a correct run ends far earlier.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Fill from the seed with the 6069 multiplier; position lands on the end,
  // so the draw that follows always twists first.
  function automatic void shadow_fill();
    shadow_table[0] = shadow_seed;
    for (int i = 1; i < mtwg_pkg::STATE_LENGTH; i++)
      shadow_table[i] = shadow_table[i-1] * mtwg_pkg::SEED_MULT;
    shadow_pos = mtwg_pkg::STATE_LENGTH;
  endfunction

  // Full in-place twist of the table. Entries below k are already new,
  // matching the usual in-place recurrence.
  function automatic void shadow_twist();
    mtwg_pkg::word_t mix;
    mtwg_pkg::word_t mag;
    for (int k = 0; k < mtwg_pkg::STATE_LENGTH; k++) begin
      mix = (shadow_table[k] & mtwg_pkg::HIGH_BIT) |
            (shadow_table[(k + 1) % mtwg_pkg::STATE_LENGTH] & mtwg_pkg::LOW_BITS);
      mag = mix[0] ? mtwg_pkg::MATRIX_A : '0;
      shadow_table[k] =
        shadow_table[(k + mtwg_pkg::TWIST_OFFSET) % mtwg_pkg::STATE_LENGTH] ^
        (mix >> 1) ^ mag;
    end
    shadow_pos = 0;
  endfunction

  // Tempered word for one accepted request; advances the shadow state.
  function automatic mtwg_pkg::word_t predict_word(input logic reseed);
    mtwg_pkg::word_t w;
    if (reseed || shadow_pos > mtwg_pkg::STATE_LENGTH)
      shadow_fill();
    if (shadow_pos >= mtwg_pkg::STATE_LENGTH)
      shadow_twist();
    w = shadow_table[shadow_pos % mtwg_pkg::STATE_LENGTH];
    shadow_pos++;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & mtwg_pkg::TEMPER_B);
    w = w ^ ((w << 15) & mtwg_pkg::TEMPER_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random ready, with an optional long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_cycles;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        hold_cycles = stall_request;
        stall_request = 0;
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Result checker: every word taken from the block is matched against the
  // oldest prediction. Only the first ten problems are printed.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word %h with no request outstanding", out_random_word);
      end else begin
        if (out_random_word !== pending_words[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("random_word mismatch: expected %h, got %h",
                     pending_words[0], out_random_word);
        end
        void'(pending_words.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one draw request, with random idle cycles ahead of it, and hold it
  // until accepted. The prediction is made at the accepting edge.
  task automatic send_draw(input logic reseed);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_reseed <= reseed;
    do @(posedge clk); while (!in_ready);
    pending_words.push_back(predict_word(reseed));
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // Seed register write, only with the block idle.
  task automatic write_seed(input mtwg_pkg::word_t value);
    drain_words();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_seed = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First request after reset seeds from the reset seed even without reseed.
  task automatic test_first_draws();
    repeat (4) send_draw(1'b0);
  endtask

  // Reseed with the same seed restarts the stream from the top.
  task automatic test_reseed_restart();
    send_draw(1'b1);
    repeat (2) send_draw(1'b0);
    send_draw(1'b1);
  endtask

  // Seed register at its extremes and back to the reset value.
  task automatic test_seed_extremes();
    write_seed(32'h0000_0000);
    send_draw(1'b1);
    repeat (2) send_draw(1'b0);
    write_seed(32'hffff_ffff);
    send_draw(1'b1);
    repeat (2) send_draw(1'b0);
    write_seed(32'h0000_0001);
    send_draw(1'b1);
    send_draw(1'b0);
    write_seed(mtwg_pkg::SEED_DEFAULT);
    send_draw(1'b1);
    send_draw(1'b0);
  endtask

  // Receiver holds off while requests keep coming, so the block fills and
  // stalls its input; then the sender waits for everything to come back.
  task automatic test_backpressure();
    drain_words();
    stall_request = 300;
    repeat (40) send_draw(1'b0);
    drain_words();
  endtask

  // Random phases, each with a fresh seed and a reseeding request first.
  // Each phase draws 280 more words, fewer than one table, so no table end past
  // the first twist is reached; one phase runs with no idling on either side.
  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      write_seed((p == 0) ? 32'h8000_0000 : mtwg_pkg::word_t'($urandom));
      idle_pct = (p == 2) ? 0 : 31;
      send_draw(1'b1);
      repeat (280) send_draw($urandom_range(63) == 0);
    end
    idle_pct = 31;
  endtask

  initial begin
    shadow_seed = mtwg_pkg::SEED_DEFAULT;
    shadow_pos  = mtwg_pkg::STATE_LENGTH + 1;
    for (int i = 0; i < mtwg_pkg::STATE_LENGTH; i++)
      shadow_table[i] = '0;

    // Synchronous reset, released on an edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_draws();
    test_reseed_restart();
    test_seed_extremes();
    test_backpressure();
    test_random_phases();

    drain_words();
    repeat (16) @(posedge clk);

    if (pending_words.size() != 0) begin
      mismatch_count++;
      $display("%0d predicted words never arrived", pending_words.size());
    end
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
